// ===== rtl/mcr_pkg.sv =====
// mcr_pkg: shared types and constants for the midpoint circle rasterizer
// no dependencies; imported by every module of the block

package mcr_pkg;

    // point coordinate width, default and upper bound
    localparam int COORD_BITS_DEF = 16;
    localparam int COORD_BITS_MAX = 32;

    // step descriptor queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // field widths fixed by the item format
    localparam int CENTER_BITS = 15;
    localparam int RADIUS_BITS = 14;
    localparam int OFFSET_BITS = 15;
    localparam int STEP_BITS   = 16;
    localparam int ERROR_BITS  = 18;
    localparam int SUM_BITS    = 16;

    // number of points per step and phase counter width
    localparam int POINTS_PER_STEP = 8;
    localparam int PHASE_BITS      = 3;
    localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd7;

    // input opcodes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // one step as handed from front to back
    typedef struct packed {
        logic signed [CENTER_BITS-1:0] center_col;
        logic signed [CENTER_BITS-1:0] center_row;
        logic signed [OFFSET_BITS-1:0] offset_x;
        logic signed [OFFSET_BITS-1:0] offset_y;
        logic                          done;
    } mcr_step_t;

endpackage

// ===== rtl/mcr_front.sv =====
// mcr_front: accepts items, holds the walk state and issues step descriptors
// depends on mcr_pkg

module mcr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic signed [mcr_pkg::CENTER_BITS-1:0] center_x,
    input  logic signed [mcr_pkg::CENTER_BITS-1:0] center_y,
    input  logic        [mcr_pkg::RADIUS_BITS-1:0] radius,
    output logic                                push,
    output mcr_pkg::mcr_step_t                  push_step,
    input  logic                                queue_full
);
    import mcr_pkg::*;

    logic signed [CENTER_BITS-1:0] center_col_reg, center_col_next;
    logic signed [CENTER_BITS-1:0] center_row_reg, center_row_next;
    logic        [RADIUS_BITS-1:0] radius_held_reg, radius_held_next;
    logic signed [OFFSET_BITS-1:0] offset_x_reg, offset_x_next;
    logic signed [OFFSET_BITS-1:0] offset_y_reg, offset_y_next;
    logic        [STEP_BITS-1:0]   step_x_reg, step_x_next;
    logic        [STEP_BITS-1:0]   step_y_reg, step_y_next;
    logic signed [ERROR_BITS-1:0]  error_term_reg, error_term_next;
    logic                          active_reg, active_next;

    logic                          accept;
    logic                          err_le0;
    logic                          err1_gt0;
    logic signed [ERROR_BITS-1:0]  two_r;
    logic signed [ERROR_BITS-1:0]  err1;
    logic signed [ERROR_BITS-1:0]  err2;
    logic        [STEP_BITS-1:0]   sy1;
    logic        [STEP_BITS-1:0]   sx1;
    logic signed [OFFSET_BITS-1:0] oy1;
    logic signed [OFFSET_BITS-1:0] ox1;
    logic                          done;
    logic signed [ERROR_BITS-1:0]  two_r_in;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // walk update, y move first then x move on the updated error
    always_comb
    begin
        two_r    = signed'({3'b000, radius_held_reg, 1'b0});
        err_le0  = (error_term_reg <= 0);
        err1     = err_le0 ? ERROR_BITS'(error_term_reg + signed'({2'b00, step_y_reg}))
                           : error_term_reg;
        sy1      = err_le0 ? STEP_BITS'(step_y_reg + 16'd2) : step_y_reg;
        oy1      = err_le0 ? OFFSET_BITS'(offset_y_reg + 15'sd1) : offset_y_reg;
        err1_gt0 = (err1 > 0);
        sx1      = err1_gt0 ? STEP_BITS'(step_x_reg + 16'd2) : step_x_reg;
        ox1      = err1_gt0 ? OFFSET_BITS'(offset_x_reg - 15'sd1) : offset_x_reg;
        err2     = err1_gt0 ? ERROR_BITS'(err1 + signed'({2'b00, sx1}) - two_r) : err1;
        done     = (ox1 < oy1);
        two_r_in = signed'({3'b000, radius, 1'b0});
    end

    // item decode and state next values
    always_comb
    begin
        center_col_next  = center_col_reg;
        center_row_next  = center_row_reg;
        radius_held_next = radius_held_reg;
        offset_x_next    = offset_x_reg;
        offset_y_next    = offset_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        error_term_next  = error_term_reg;
        active_next      = active_reg;
        push             = 1'b0;
        if (accept)
        begin
            unique case (op_t'(op))
                OP_START:
                begin
                    center_col_next  = center_x;
                    center_row_next  = center_y;
                    radius_held_next = radius;
                    offset_x_next    = signed'(OFFSET_BITS'({1'b0, radius} - 15'd1));
                    offset_y_next    = '0;
                    step_x_next      = 16'd1;
                    step_y_next      = 16'd1;
                    error_term_next  = ERROR_BITS'(18'sd1 - two_r_in);
                    active_next      = (radius != '0);
                end
                OP_STEP:
                begin
                    if (active_reg)
                    begin
                        push            = 1'b1;
                        offset_x_next   = ox1;
                        offset_y_next   = oy1;
                        step_x_next     = sx1;
                        step_y_next     = sy1;
                        error_term_next = err2;
                        active_next     = !done;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // descriptor carries the offsets before the update
    always_comb
    begin
        push_step.center_col = center_col_reg;
        push_step.center_row = center_row_reg;
        push_step.offset_x   = offset_x_reg;
        push_step.offset_y   = offset_y_reg;
        push_step.done       = done;
    end

    // walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg  <= '0;
            center_row_reg  <= '0;
            radius_held_reg <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            step_x_reg      <= 16'd1;
            step_y_reg      <= 16'd1;
            error_term_reg  <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            center_col_reg  <= center_col_next;
            center_row_reg  <= center_row_next;
            radius_held_reg <= radius_held_next;
            offset_x_reg    <= offset_x_next;
            offset_y_reg    <= offset_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            error_term_reg  <= error_term_next;
            active_reg      <= active_next;
        end
    end

endmodule

// ===== rtl/mcr_queue.sv =====
// mcr_queue: small fifo of step descriptors between front and back
// depends on mcr_pkg

module mcr_queue #(
    parameter int DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mcr_pkg::mcr_step_t push_step,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output mcr_pkg::mcr_step_t pop_step
);
    import mcr_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    mcr_step_t           entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_step  = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_BITS'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_BITS'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_BITS'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_BITS'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_step;
        end
    end

endmodule

// ===== rtl/mcr_back.sv =====
// mcr_back: expands each step descriptor into eight outline points
// depends on mcr_pkg

module mcr_back #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_avail,
    input  mcr_pkg::mcr_step_t           step_in,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last_of_step,
    output logic                         circle_done
);
    import mcr_pkg::*;

    mcr_step_t                 work_reg;
    logic                      work_valid_reg, work_valid_next;
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] point_x_reg;
    logic signed [COORD_BITS-1:0] point_y_reg;
    logic                      last_reg;
    logic                      done_reg;

    logic                      adv;
    logic                      at_last;
    logic signed [OFFSET_BITS-1:0] x_off;
    logic signed [OFFSET_BITS-1:0] y_off;
    logic signed [SUM_BITS-1:0]    px_sum;
    logic signed [SUM_BITS-1:0]    py_sum;
    logic signed [COORD_BITS_MAX-1:0] px_wide;
    logic signed [COORD_BITS_MAX-1:0] py_wide;

    assign adv     = work_valid_reg && (!out_valid_reg || out_ready);
    assign at_last = (phase_reg == PHASE_LAST);
    assign pop     = step_avail && (!work_valid_reg || (adv && at_last));

    // point for the current phase: bit 2 swaps offsets, bit 1 negates x, bit 0 adds y
    always_comb
    begin
        x_off   = phase_reg[2] ? work_reg.offset_y : work_reg.offset_x;
        y_off   = phase_reg[2] ? work_reg.offset_x : work_reg.offset_y;
        px_sum  = phase_reg[1] ? SUM_BITS'(SUM_BITS'(work_reg.center_col) - SUM_BITS'(x_off))
                               : SUM_BITS'(SUM_BITS'(work_reg.center_col) + SUM_BITS'(x_off));
        py_sum  = phase_reg[0] ? SUM_BITS'(SUM_BITS'(work_reg.center_row) + SUM_BITS'(y_off))
                               : SUM_BITS'(SUM_BITS'(work_reg.center_row) - SUM_BITS'(y_off));
        px_wide = COORD_BITS_MAX'(px_sum);
        py_wide = COORD_BITS_MAX'(py_sum);
    end

    // phase counter and output valid
    always_comb
    begin
        work_valid_next = work_valid_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            phase_next     = PHASE_BITS'(phase_reg + 1'b1);
            if (at_last)
            begin
                work_valid_next = step_avail;
            end
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_next = 1'b0;
            end
            if (!work_valid_reg)
            begin
                work_valid_next = step_avail;
                phase_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // descriptor and output payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= step_in;
        end
        if (adv)
        begin
            point_x_reg <= px_wide[COORD_BITS-1:0];
            point_y_reg <= py_wide[COORD_BITS-1:0];
            last_reg    <= at_last;
            done_reg    <= work_reg.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
// midpoint_circle_rasterizer: top level of the midpoint circle outline generator
// depends on mcr_pkg, mcr_front, mcr_queue, mcr_back
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, op, center_x,           into block
//            center_y, radius
//   out      out_valid/out_ready, point_x, point_y,     out of block
//            last_of_step, circle_done
//
// start items and steps with no active circle are taken in the front and
// push nothing. each active step yields eight points, one per cycle through
// the back's output register while out_ready does not stall it. the front
// keeps accepting while the queue has room; an output stall backs up into
// the queue and then into in_ready.
// reset is asynchronous and clears the walk state, queue and output valid.

module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic signed [mcr_pkg::CENTER_BITS-1:0] center_x,
    input  logic signed [mcr_pkg::CENTER_BITS-1:0] center_y,
    input  logic        [mcr_pkg::RADIUS_BITS-1:0] radius,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [COORD_BITS-1:0]           point_x,
    output logic signed [COORD_BITS-1:0]           point_y,
    output logic                                   last_of_step,
    output logic                                   circle_done
);
    import mcr_pkg::*;

    logic      push;
    mcr_step_t push_step;
    logic      queue_full;
    logic      pop;
    logic      queue_not_empty;
    mcr_step_t pop_step;

    // walk state and item decode
    mcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .push       (push),
        .push_step  (push_step),
        .queue_full (queue_full)
    );

    // step descriptor queue
    mcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_step (push_step),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_step  (pop_step)
    );

    // point emitter
    mcr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_avail   (queue_not_empty),
        .step_in      (pop_step),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule
